>>> sv/rtcpt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the real-time counter with periodic timer.
// Used by rtcpt_core and rtc_counter_with_periodic_timer; depends on nothing.

package rtcpt_pkg;

  // Request codes
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;
  localparam logic [1:0] CmdSleep = 2'd3;

  // Sleep levels that matter to the counter
  localparam logic [1:0] SleepStandby   = 2'd2;
  localparam logic [1:0] SleepPowerDown = 2'd3;

  // Register offsets
  localparam logic [4:0] OfsCtrlA       = 5'h00;
  localparam logic [4:0] OfsStatus      = 5'h01;
  localparam logic [4:0] OfsIntCtrl     = 5'h02;
  localparam logic [4:0] OfsIntFlags    = 5'h03;
  localparam logic [4:0] OfsTemp        = 5'h04;
  localparam logic [4:0] OfsClkSel      = 5'h07;
  localparam logic [4:0] OfsCntL        = 5'h08;
  localparam logic [4:0] OfsCntH        = 5'h09;
  localparam logic [4:0] OfsPerL        = 5'h0A;
  localparam logic [4:0] OfsPerH        = 5'h0B;
  localparam logic [4:0] OfsCmpL        = 5'h0C;
  localparam logic [4:0] OfsCmpH        = 5'h0D;
  localparam logic [4:0] OfsPitCtrlA    = 5'h10;
  localparam logic [4:0] OfsPitStatus   = 5'h11;
  localparam logic [4:0] OfsPitIntCtrl  = 5'h12;
  localparam logic [4:0] OfsPitIntFlags = 5'h13;

  // Writable bit masks
  localparam logic [7:0] CtrlAMask    = 8'hF9;
  localparam logic [7:0] PitCtrlAMask = 8'h79;

  // Counter range: the count wraps to zero on reaching it
  localparam int unsigned CounterRange = 65536;
  localparam logic [15:0] PeriodReset  = 16'hFFFF;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic [1:0] sleep_level;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rtc_irq;
    logic       pit_irq;
  } out_req_t;

endpackage

>>> sv/rtcpt_core.sv
`timescale 1ns / 1ps
// Register file, prescaler, counter and periodic timer; one request per step.
// Depends on rtcpt_pkg.

module rtcpt_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  rtcpt_pkg::in_req_t  req_i,
  output rtcpt_pkg::out_req_t rsp_o
);

  logic [7:0]  ctrl_a_q, ctrl_a_d;
  logic [1:0]  clksel_q, clksel_d;
  logic [1:0]  inten_q, inten_d;
  logic [1:0]  flags_q, flags_d;
  logic [7:0]  temp_q, temp_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] per_q, per_d;
  logic [15:0] cmp_q, cmp_d;
  logic [7:0]  pitctrl_q, pitctrl_d;
  logic        pitinten_q, pitinten_d;
  logic        pitflag_q, pitflag_d;
  logic [15:0] pitcnt_q, pitcnt_d;
  logic [14:0] presc_q, presc_d;
  logic [1:0]  sleep_q, sleep_d;

  logic [7:0]  rd_data;
  logic [15:0] joined;
  logic [15:0] presc_span;
  logic [14:0] presc_last;
  logic [16:0] pit_span;
  logic [15:0] pit_last;
  logic [16:0] cnt_inc;
  logic [15:0] cnt_next;
  logic        paused;
  logic        pit_run;
  logic        ptick;

  assign joined     = {req_i.write_data, temp_q};
  assign presc_span = 16'd1 << ctrl_a_q[6:3];
  assign presc_last = presc_span[14:0] - 15'd1;
  assign pit_span   = 17'd1 << ({1'b0, pitctrl_q[6:3]} + 5'd1);
  assign pit_last   = pit_span[15:0] - 16'd1;
  assign cnt_inc    = {1'b0, cnt_q} + 17'd1;
  assign cnt_next   = (cnt_inc >= 17'(rtcpt_pkg::CounterRange)) ? 16'd0 : cnt_inc[15:0];
  assign paused     = (sleep_q == rtcpt_pkg::SleepPowerDown) ||
                      ((sleep_q == rtcpt_pkg::SleepStandby) && !ctrl_a_q[7]);
  assign pit_run    = pitctrl_q[0] && (pitctrl_q[6:3] != 4'd0);

  always_comb begin
    ctrl_a_d   = ctrl_a_q;
    clksel_d   = clksel_q;
    inten_d    = inten_q;
    flags_d    = flags_q;
    temp_d     = temp_q;
    cnt_d      = cnt_q;
    per_d      = per_q;
    cmp_d      = cmp_q;
    pitctrl_d  = pitctrl_q;
    pitinten_d = pitinten_q;
    pitflag_d  = pitflag_q;
    pitcnt_d   = pitcnt_q;
    presc_d    = presc_q;
    sleep_d    = sleep_q;
    rd_data    = 8'd0;
    ptick      = 1'b0;

    case (req_i.command)
      rtcpt_pkg::CmdRead: begin
        case (req_i.reg_offset)
          rtcpt_pkg::OfsCtrlA:       rd_data = ctrl_a_q;
          rtcpt_pkg::OfsIntCtrl:     rd_data = {6'd0, inten_q};
          rtcpt_pkg::OfsIntFlags:    rd_data = {6'd0, flags_q};
          rtcpt_pkg::OfsTemp:        rd_data = temp_q;
          rtcpt_pkg::OfsClkSel:      rd_data = {6'd0, clksel_q};
          rtcpt_pkg::OfsCntL: begin
            rd_data = cnt_q[7:0];
            temp_d  = cnt_q[15:8];
          end
          rtcpt_pkg::OfsPerL: begin
            rd_data = per_q[7:0];
            temp_d  = per_q[15:8];
          end
          rtcpt_pkg::OfsCmpL: begin
            rd_data = cmp_q[7:0];
            temp_d  = cmp_q[15:8];
          end
          rtcpt_pkg::OfsCntH, rtcpt_pkg::OfsPerH, rtcpt_pkg::OfsCmpH: rd_data = temp_q;
          rtcpt_pkg::OfsPitCtrlA:    rd_data = pitctrl_q;
          rtcpt_pkg::OfsPitIntCtrl:  rd_data = {7'd0, pitinten_q};
          rtcpt_pkg::OfsPitIntFlags: rd_data = {7'd0, pitflag_q};
          default:                   rd_data = 8'd0;
        endcase
      end
      rtcpt_pkg::CmdWrite: begin
        case (req_i.reg_offset)
          rtcpt_pkg::OfsCtrlA:    ctrl_a_d = req_i.write_data & rtcpt_pkg::CtrlAMask;
          rtcpt_pkg::OfsIntCtrl:  inten_d  = req_i.write_data[1:0];
          rtcpt_pkg::OfsIntFlags: flags_d  = flags_q & ~req_i.write_data[1:0];
          rtcpt_pkg::OfsTemp, rtcpt_pkg::OfsCntL, rtcpt_pkg::OfsPerL, rtcpt_pkg::OfsCmpL:
            temp_d = req_i.write_data;
          rtcpt_pkg::OfsClkSel:   clksel_d = req_i.write_data[1:0];
          rtcpt_pkg::OfsCntH:     cnt_d    = joined;
          rtcpt_pkg::OfsPerH:     per_d    = joined;
          rtcpt_pkg::OfsCmpH:     cmp_d    = joined;
          rtcpt_pkg::OfsPitCtrlA: pitctrl_d = req_i.write_data & rtcpt_pkg::PitCtrlAMask;
          rtcpt_pkg::OfsPitIntCtrl: pitinten_d = req_i.write_data[0];
          rtcpt_pkg::OfsPitIntFlags: begin
            if (req_i.write_data[0]) begin
              pitflag_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      rtcpt_pkg::CmdTick: begin
        // Hold the prescaler at zero while both timers are off
        if (!ctrl_a_q[0] && !pitctrl_q[0]) begin
          presc_d = 15'd0;
        end else if (presc_q >= presc_last) begin
          presc_d = 15'd0;
          ptick   = 1'b1;
        end else begin
          presc_d = presc_q + 15'd1;
        end

        if (ptick && ctrl_a_q[0] && !paused) begin
          cnt_d = cnt_next;
          if (cnt_next == cmp_q) begin
            flags_d[1] = 1'b1;
          end
          if (cnt_next == per_q) begin
            cnt_d      = 16'd0;
            flags_d[0] = 1'b1;
          end
        end

        if (ptick && pit_run) begin
          if (pitcnt_q >= pit_last) begin
            pitcnt_d  = 16'd0;
            pitflag_d = 1'b1;
          end else begin
            pitcnt_d = pitcnt_q + 16'd1;
          end
        end
      end
      rtcpt_pkg::CmdSleep: sleep_d = req_i.sleep_level;
      default: ;
    endcase
  end

  assign rsp_o.read_data = rd_data;
  assign rsp_o.rtc_irq   = |(flags_d & inten_d);
  assign rsp_o.pit_irq   = pitflag_d & pitinten_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q   <= 8'd0;
      clksel_q   <= 2'd0;
      inten_q    <= 2'd0;
      flags_q    <= 2'd0;
      temp_q     <= 8'd0;
      cnt_q      <= 16'd0;
      per_q      <= rtcpt_pkg::PeriodReset;
      cmp_q      <= 16'd0;
      pitctrl_q  <= 8'd0;
      pitinten_q <= 1'b0;
      pitflag_q  <= 1'b0;
      pitcnt_q   <= 16'd0;
      presc_q    <= 15'd0;
      sleep_q    <= 2'd0;
    end else if (step_i) begin
      ctrl_a_q   <= ctrl_a_d;
      clksel_q   <= clksel_d;
      inten_q    <= inten_d;
      flags_q    <= flags_d;
      temp_q     <= temp_d;
      cnt_q      <= cnt_d;
      per_q      <= per_d;
      cmp_q      <= cmp_d;
      pitctrl_q  <= pitctrl_d;
      pitinten_q <= pitinten_d;
      pitflag_q  <= pitflag_d;
      pitcnt_q   <= pitcnt_d;
      presc_q    <= presc_d;
      sleep_q    <= sleep_d;
    end
  end

endmodule

>>> sv/rtc_counter_with_periodic_timer.sv
`timescale 1ns / 1ps
// Top level of the real-time counter with periodic timer: request and result registers.
// Depends on rtcpt_pkg and rtcpt_core.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+--------------------------------------------
//   in      | in_valid_i  | in_stall_o  | in_req_i  (command, offset, data, sleep)
//   out     | out_valid_o | out_stall_i | out_req_o (read_data, rtc_irq, pit_irq)
//
// One request per clock cycle sustained while the output does not stall; each result
// passes through the request register, then the result register.
// A request updates the counter state at the edge where it moves into the result
// register, so state changes follow request order exactly.
// Reset clears all counter and timer state (PER to all ones) and empties both stages.
// A stall on the output holds the result; an empty request register still takes one more
// request, and in_stall_o rises once the request register holds one.

module rtc_counter_with_periodic_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rtcpt_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rtcpt_pkg::out_req_t out_req_o
);

  logic                in_valid_q, in_valid_d;
  rtcpt_pkg::in_req_t  in_req_q;
  logic                out_valid_q, out_valid_d;
  rtcpt_pkg::out_req_t out_req_q;
  rtcpt_pkg::out_req_t core_rsp;
  logic                advance;
  logic                fire;
  logic                take_in;

  // The result register can load when empty or when its result is taken now
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_in) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  rtcpt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .req_i  (in_req_q),
    .rsp_o  (core_rsp)
  );

  // Control: valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: capture the request, hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_req_q <= core_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule
